// File: sv/dscrs_pkg.sv
// Package: shared types, record constants, CRC step and microcode table for the record store.
`default_nettype none
package dscrs_pkg;

    localparam int SLOT_BYTES     = 32;
    localparam int OFF_W          = $clog2(SLOT_BYTES);
    localparam int GEN_OFFSET     = 6;
    localparam int SCORES_OFFSET  = 8;
    localparam logic [7:0]  FORMAT_VERSION = 8'd1;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [1:0]  NO_BANK        = 2'd2;

    typedef enum logic [1:0] {
        OP_SCAN   = 2'd0,
        OP_FINISH = 2'd1,
        OP_STORE  = 2'd2,
        OP_COMMIT = 2'd3
    } op_t;

    typedef struct packed {
        op_t              opcode;
        logic             slot_select;
        logic [OFF_W-1:0] byte_offset;
        logic [15:0]      data;
        logic [3:0]       score_index;
    } cmd_t;

    typedef struct packed {
        logic             kind;
        logic             out_slot;
        logic [OFF_W-1:0] out_offset;
        logic [15:0]      value;
        logic [3:0]       score_position;
        logic             record_found;
        logic [15:0]      generation;
        logic             last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_DISPATCH  = 3'd0,
        ST_FIN_SEL   = 3'd1,
        ST_FIN_EMIT  = 3'd2,
        ST_COM_START = 3'd3,
        ST_COM_BYTES = 3'd4,
        ST_COM_MAGIC = 3'd5
    } step_t;

    typedef enum logic [2:0] {
        EM_NONE  = 3'd0,
        EM_SCORE = 3'd1,
        EM_ZERO0 = 3'd2,
        EM_BYTE  = 3'd3,
        EM_MAGIC = 3'd4
    } emit_t;

    typedef enum logic [1:0] {
        C_ALWAYS   = 2'd0,
        C_CNT_END  = 2'd1,
        C_DISPATCH = 2'd2
    } cond_t;

    typedef struct packed {
        logic  accept;
        emit_t emit;
        logic  fin_sel;
        logic  clear_on_end;
        logic  commit_init;
        cond_t cond;
        step_t target;
    } ctl_t;

    typedef struct packed {
        logic out_free;
        logic cnt_end;
    } dp_stat_t;

    typedef struct packed {
        logic [1:0]  good;
        logic [15:0] gen0;
        logic [15:0] gen1;
    } scan_view_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h53;
            2'd1:    m = 8'h43;
            2'd2:    m = 8'h56;
            default: m = 8'h31;
        endcase
        return m;
    endfunction

    function automatic logic newer(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return (d != 16'd0) && !d[15];
    endfunction

    function automatic step_t dispatch(input op_t op);
        step_t s;
        case (op)
            OP_FINISH: s = ST_FIN_SEL;
            OP_COMMIT: s = ST_COM_START;
            default:   s = ST_DISPATCH;
        endcase
        return s;
    endfunction

    function automatic ctl_t ucode(input step_t s);
        ctl_t c;
        c = '{accept: 1'b0, emit: EM_NONE, fin_sel: 1'b0, clear_on_end: 1'b0,
              commit_init: 1'b0, cond: C_ALWAYS, target: ST_DISPATCH};
        case (s)
            ST_FIN_SEL:
            begin
                c.fin_sel = 1'b1;
                c.target  = ST_FIN_EMIT;
            end
            ST_FIN_EMIT:
            begin
                c.emit         = EM_SCORE;
                c.clear_on_end = 1'b1;
                c.cond         = C_CNT_END;
                c.target       = ST_DISPATCH;
            end
            ST_COM_START:
            begin
                c.emit        = EM_ZERO0;
                c.commit_init = 1'b1;
                c.target      = ST_COM_BYTES;
            end
            ST_COM_BYTES:
            begin
                c.emit   = EM_BYTE;
                c.cond   = C_CNT_END;
                c.target = ST_COM_MAGIC;
            end
            ST_COM_MAGIC:
            begin
                c.emit   = EM_MAGIC;
                c.target = ST_DISPATCH;
            end
            default:
            begin
                c.accept = 1'b1;
                c.cond   = C_DISPATCH;
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: sv/dual_slot_crc_record_store_top.sv
// Top level of the dual-slot record store with CRC-16 check.
//
//  channel | signals                   | direction | carries
//  cmd     | cmd_valid, cmd_stall, cmd | in        | scan byte, finish, store score, commit
//  rsp     | rsp_valid, rsp_stall, rsp | out       | loaded scores, slot byte writes
//
// Scan and store requests are taken in the dispatch step and may follow back to back.
// Finish and commit run as microcode steps that emit one result per cycle into the
// single output register while rsp_stall does not hold it; rsp_stall freezes the
// current emit step, and cmd_stall is high outside the dispatch step.
// Reset is asynchronous; no clearing pass is needed after it.
`default_nettype none
module dual_slot_crc_record_store_top #(
    parameter int SCORE_COUNT = 5
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_stall,
    input  wire dscrs_pkg::cmd_t cmd,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output dscrs_pkg::rsp_t      rsp
);
    import dscrs_pkg::*;

    localparam int SIDX_W = (SCORE_COUNT > 1) ? $clog2(SCORE_COUNT) : 1;

    ctl_t              ctl;
    dp_stat_t          stat;
    scan_view_t        view;
    logic              accept;
    logic              scan_clear;
    logic              rd_slot;
    logic [SIDX_W-1:0] rd_idx;
    logic [15:0]       rd_score;

    assign cmd_stall = !ctl.accept;
    assign accept    = cmd_valid && ctl.accept;

    dscrs_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .opcode    (cmd.opcode),
        .stat      (stat),
        .ctl       (ctl)
    );

    dscrs_scan #(
        .SCORE_COUNT (SCORE_COUNT),
        .SIDX_W      (SIDX_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan_en   (accept && (cmd.opcode == OP_SCAN)),
        .slot      (cmd.slot_select),
        .offset    (cmd.byte_offset),
        .byte_in   (cmd.data[7:0]),
        .clear_all (scan_clear),
        .rd_slot   (rd_slot),
        .rd_idx    (rd_idx),
        .view      (view),
        .rd_score  (rd_score)
    );

    dscrs_dp #(
        .SCORE_COUNT (SCORE_COUNT),
        .SIDX_W      (SIDX_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .accept     (accept),
        .cmd        (cmd),
        .view       (view),
        .rd_score   (rd_score),
        .rsp_stall  (rsp_stall),
        .rd_slot    (rd_slot),
        .rd_idx     (rd_idx),
        .scan_clear (scan_clear),
        .stat       (stat),
        .rsp_valid  (rsp_valid),
        .rsp        (rsp)
    );

endmodule
`default_nettype wire

// File: sv/dscrs_seq.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
`default_nettype none
module dscrs_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire dscrs_pkg::op_t     opcode,
    input  wire dscrs_pkg::dp_stat_t stat,
    output dscrs_pkg::ctl_t         ctl
);
    import dscrs_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  hold;

    always_comb
    begin
        ctl = ucode(step_reg);
    end

    always_comb
    begin
        hold      = (ctl.emit != EM_NONE) && !stat.out_free;
        step_next = step_reg;
        case (ctl.cond)
            C_DISPATCH:
            begin
                if (cmd_valid)
                    step_next = dispatch(opcode);
            end
            C_CNT_END:
            begin
                if (!hold && stat.cnt_end)
                    step_next = ctl.target;
            end
            C_ALWAYS:
            begin
                if (!hold)
                    step_next = ctl.target;
            end
            default:
            begin
                step_next = ST_DISPATCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ST_DISPATCH;
        else
            step_reg <= step_next;
    end

endmodule
`default_nettype wire

// File: sv/dscrs_scan.sv
// Per-slot scan state: running CRC, header check, stored check, generation and scores.
`default_nettype none
module dscrs_scan #(
    parameter int SCORE_COUNT = 5,
    parameter int SIDX_W      = 3
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    scan_en,
    input  wire logic                    slot,
    input  wire logic [dscrs_pkg::OFF_W-1:0] offset,
    input  wire logic [7:0]              byte_in,
    input  wire logic                    clear_all,
    input  wire logic                    rd_slot,
    input  wire logic [SIDX_W-1:0]       rd_idx,
    output dscrs_pkg::scan_view_t        view,
    output logic [15:0]                  rd_score
);
    import dscrs_pkg::*;

    localparam logic [OFF_W-1:0] CHECK_OFF = OFF_W'(SCORES_OFFSET + 2 * SCORE_COUNT);
    localparam logic [OFF_W-1:0] SCORE_OFF = OFF_W'(SCORES_OFFSET);
    localparam logic [OFF_W-1:0] GEN_OFF   = OFF_W'(GEN_OFFSET);
    localparam logic [7:0]       LEN_BYTE  = 8'(2 * SCORE_COUNT);

    logic [15:0] crc_reg [2];
    logic        hdr_reg [2];
    logic [15:0] chk_reg [2];
    logic [15:0] gen_reg [2];
    logic [15:0] scores_reg [2][SCORE_COUNT];

    logic [15:0]      crc_next;
    logic             hdr_next;
    logic [15:0]      chk_next;
    logic [15:0]      gen_next;
    logic [OFF_W-1:0] rel;
    logic [SIDX_W-1:0] widx;
    logic             score_wr;

    always_comb
    begin
        if (offset == '0)
        begin
            crc_next = CRC_INIT;
            hdr_next = 1'b1;
            chk_next = 16'd0;
            gen_next = 16'd0;
        end
        else
        begin
            crc_next = crc_reg[slot];
            hdr_next = hdr_reg[slot];
            chk_next = chk_reg[slot];
            gen_next = gen_reg[slot];
        end
        rel      = offset - SCORE_OFF;
        widx     = rel[SIDX_W:1];
        score_wr = 1'b0;
        if (offset < CHECK_OFF)
        begin
            crc_next = crc_byte(crc_next, byte_in);
            if (offset < OFF_W'(4))
            begin
                if (byte_in != magic_byte(offset[1:0]))
                    hdr_next = 1'b0;
            end
            else if (offset == OFF_W'(4))
            begin
                if (byte_in != FORMAT_VERSION)
                    hdr_next = 1'b0;
            end
            else if (offset == OFF_W'(5))
            begin
                if (byte_in != LEN_BYTE)
                    hdr_next = 1'b0;
            end
            else if (offset == GEN_OFF)
                gen_next = {gen_next[15:8], byte_in};
            else if (offset == GEN_OFF + OFF_W'(1))
                gen_next = {byte_in, gen_next[7:0]};
            else
                score_wr = 1'b1;
        end
        else if (offset == CHECK_OFF)
            chk_next = {chk_next[15:8], byte_in};
        else if (offset == CHECK_OFF + OFF_W'(1))
            chk_next = {byte_in, chk_next[7:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 2; k++)
            begin
                crc_reg[k] <= CRC_INIT;
                hdr_reg[k] <= 1'b1;
                chk_reg[k] <= 16'd0;
                gen_reg[k] <= 16'd0;
            end
        end
        else if (clear_all)
        begin
            for (int k = 0; k < 2; k++)
            begin
                crc_reg[k] <= CRC_INIT;
                hdr_reg[k] <= 1'b1;
                chk_reg[k] <= 16'd0;
                gen_reg[k] <= 16'd0;
            end
        end
        else if (scan_en)
        begin
            crc_reg[slot] <= crc_next;
            hdr_reg[slot] <= hdr_next;
            chk_reg[slot] <= chk_next;
            gen_reg[slot] <= gen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_en && score_wr)
        begin
            if (rel[0])
                scores_reg[slot][widx][15:8] <= byte_in;
            else
                scores_reg[slot][widx][7:0] <= byte_in;
        end
    end

    always_comb
    begin
        view.good[0] = hdr_reg[0] && (crc_reg[0] == chk_reg[0]);
        view.good[1] = hdr_reg[1] && (crc_reg[1] == chk_reg[1]);
        view.gen0    = gen_reg[0];
        view.gen1    = gen_reg[1];
        rd_score     = scores_reg[rd_slot][rd_idx];
    end

endmodule
`default_nettype wire

// File: sv/dscrs_dp.sv
// Datapath: save buffer, active record, commit CRC, result formatting and output register.
`default_nettype none
module dscrs_dp #(
    parameter int SCORE_COUNT = 5,
    parameter int SIDX_W      = 3
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dscrs_pkg::ctl_t       ctl,
    input  wire logic                  accept,
    input  wire dscrs_pkg::cmd_t       cmd,
    input  wire dscrs_pkg::scan_view_t view,
    input  wire logic [15:0]           rd_score,
    input  wire logic                  rsp_stall,
    output logic                       rd_slot,
    output logic [SIDX_W-1:0]          rd_idx,
    output logic                       scan_clear,
    output dscrs_pkg::dp_stat_t        stat,
    output logic                       rsp_valid,
    output dscrs_pkg::rsp_t            rsp
);
    import dscrs_pkg::*;

    localparam logic [OFF_W-1:0] CHECK_OFF = OFF_W'(SCORES_OFFSET + 2 * SCORE_COUNT);
    localparam logic [OFF_W-1:0] SCORE_OFF = OFF_W'(SCORES_OFFSET);
    localparam logic [OFF_W-1:0] GEN_OFF   = OFF_W'(GEN_OFFSET);
    localparam logic [OFF_W-1:0] LAST_IDX  = OFF_W'(SCORE_COUNT - 1);
    localparam logic [7:0]       LEN_BYTE  = 8'(2 * SCORE_COUNT);

    logic [15:0]      pend_reg [SCORE_COUNT];
    logic [1:0]       bank_reg;
    logic [15:0]      count_reg;
    logic             sel_reg;
    logic             found_reg;
    logic             tgt_reg;
    logic [15:0]      crc_reg;
    logic [OFF_W-1:0] cnt_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic             fire;
    logic             sel;
    logic             found;
    logic             tgt;
    logic [OFF_W-1:0] rel;
    logic [SIDX_W-1:0] pidx;
    logic [15:0]      pword;
    logic [7:0]       rec_byte;
    rsp_t             rsp_next;

    always_comb
    begin
        found = view.good[0] || view.good[1];
        if (view.good[0] && view.good[1])
            sel = newer(view.gen1, view.gen0);
        else
            sel = view.good[1];
        tgt = (bank_reg == 2'd0);

        stat.out_free = !rsp_valid_reg || !rsp_stall;
        fire          = (ctl.emit != EM_NONE) && stat.out_free;
        case (ctl.emit)
            EM_SCORE: stat.cnt_end = (cnt_reg == LAST_IDX);
            EM_BYTE:  stat.cnt_end = (cnt_reg == CHECK_OFF + OFF_W'(1));
            default:  stat.cnt_end = 1'b0;
        endcase
        scan_clear = ctl.clear_on_end && fire && stat.cnt_end;

        rd_slot = sel_reg;
        rd_idx  = cnt_reg[SIDX_W-1:0];

        rel   = cnt_reg - SCORE_OFF;
        pidx  = rel[SIDX_W:1];
        pword = pend_reg[pidx];
        if (cnt_reg < OFF_W'(4))
            rec_byte = magic_byte(cnt_reg[1:0]);
        else if (cnt_reg == OFF_W'(4))
            rec_byte = FORMAT_VERSION;
        else if (cnt_reg == OFF_W'(5))
            rec_byte = LEN_BYTE;
        else if (cnt_reg == GEN_OFF)
            rec_byte = count_reg[7:0];
        else if (cnt_reg == GEN_OFF + OFF_W'(1))
            rec_byte = count_reg[15:8];
        else if (cnt_reg < CHECK_OFF)
            rec_byte = rel[0] ? pword[15:8] : pword[7:0];
        else if (cnt_reg == CHECK_OFF)
            rec_byte = crc_reg[7:0];
        else
            rec_byte = crc_reg[15:8];
    end

    always_comb
    begin
        rsp_next                = '0;
        rsp_next.generation     = count_reg;
        rsp_next.out_slot       = tgt_reg;
        rsp_next.kind           = 1'b1;
        case (ctl.emit)
            EM_SCORE:
            begin
                rsp_next.kind           = 1'b0;
                rsp_next.out_slot       = sel_reg;
                rsp_next.value          = found_reg ? rd_score : 16'd0;
                rsp_next.score_position = cnt_reg[3:0];
                rsp_next.record_found   = found_reg;
                rsp_next.last           = stat.cnt_end;
            end
            EM_ZERO0:
            begin
                rsp_next.out_slot   = tgt;
                rsp_next.generation = count_reg + 16'd1;
            end
            EM_BYTE:
            begin
                rsp_next.out_offset = cnt_reg;
                rsp_next.value      = {8'h00, rec_byte};
            end
            EM_MAGIC:
            begin
                rsp_next.value = {8'h00, magic_byte(2'd0)};
                rsp_next.last  = 1'b1;
            end
            default:
            begin
                rsp_next.kind = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SCORE_COUNT; k++)
                pend_reg[k] <= 16'd0;
            bank_reg      <= NO_BANK;
            count_reg     <= 16'd0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && (cmd.opcode == OP_STORE) && (cmd.score_index < 4'(SCORE_COUNT)))
                pend_reg[cmd.score_index[SIDX_W-1:0]] <= cmd.data;
            if (ctl.fin_sel)
            begin
                bank_reg  <= found ? {1'b0, sel} : NO_BANK;
                count_reg <= found ? (sel ? view.gen1 : view.gen0) : 16'd0;
                cnt_reg   <= '0;
            end
            if (fire)
            begin
                if (ctl.commit_init)
                begin
                    bank_reg  <= {1'b0, tgt};
                    count_reg <= count_reg + 16'd1;
                    cnt_reg   <= OFF_W'(1);
                end
                else
                    cnt_reg <= cnt_reg + OFF_W'(1);
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fin_sel)
        begin
            sel_reg   <= found ? sel : 1'b0;
            found_reg <= found;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
            if (ctl.commit_init)
            begin
                tgt_reg <= tgt;
                crc_reg <= crc_byte(CRC_INIT, magic_byte(2'd0));
            end
            else if (ctl.emit == EM_BYTE && cnt_reg < CHECK_OFF)
                crc_reg <= crc_byte(crc_reg, rec_byte);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

// File: sv/dscrs_check.sv
// Port checker for the record store, bound to the top level.
`default_nettype none
module dscrs_check (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            rsp_valid,
    input wire logic            rsp_stall,
    input wire dscrs_pkg::rsp_t rsp
);
    import dscrs_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    a_magic_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind && rsp.last |-> rsp.out_offset == '0 && rsp.value == 16'h0053)
        else $error("commit does not end with first magic byte");

    a_zero_first: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind && !rsp.last && rsp.out_offset == '0 |-> rsp.value == 16'd0)
        else $error("byte 0 not cleared before commit");

    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.kind && !rsp.record_found |->
            rsp.value == 16'd0 && !rsp.out_slot && rsp.generation == 16'd0)
        else $error("load without record reports data");

    a_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind |-> rsp.score_position == 4'd0 && !rsp.record_found)
        else $error("write carries load fields");

endmodule

bind dual_slot_crc_record_store_top dscrs_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
`default_nettype wire
